// ===== src/pkt_line_sideband_deframer_unit_defines.svh =====
// Assertion macros shared by the deframer RTL.
`ifndef PKT_LINE_SIDEBAND_DEFRAMER_UNIT_DEFINES_SVH
`define PKT_LINE_SIDEBAND_DEFRAMER_UNIT_DEFINES_SVH
// Checks that a condition implies a consequence on the same edge.
`define PLSD_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error(msg);
// Checks that a condition implies a consequence on the next edge.
`define PLSD_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error(msg);
`endif

// ===== src/plsd_pkg.sv =====
// Package with the types and constants of the pkt-line deframer.
package plsd_pkg;
	typedef enum logic [2:0] {
		PH_START, PH_HEADER, PH_BODY, PH_RAW, PH_ERROR
	} phase_t;
	typedef enum logic [2:0] {
		PK_UND, PK_ACK, PK_SKIP, PK_REJECT, PK_INPACK, PK_DATA, PK_PROG
	} pkind_t;
	typedef enum logic [1:0] {
		KIND_PACK = 2'd0, KIND_PROG = 2'd1, KIND_STATUS = 2'd2
	} okind_t;
	localparam logic [3:0] ST_OK = 4'd0, ST_EMPTY = 4'd1, ST_HDR_CUT = 4'd2,
		ST_BAD_LEN = 4'd3, ST_TRUNC = 4'd4, ST_ERR = 4'd5, ST_FATAL = 4'd6,
		ST_UNEXP = 4'd7, ST_INCOMPLETE = 4'd8, ST_BAD_VER = 4'd9;
	localparam int QDEPTH = 4;
	localparam int QAW = 2;
	localparam logic [5:0] PACK_MIN = 6'd32;
	localparam int HDR_BYTES = 12;

	typedef struct packed {
		logic [7:0] data;
		okind_t kind;
		logic [3:0] status;
		logic ack;
		logic [31:0] count;
		logic last;
	} res_t;

	// Queue entry: up to four magic bytes (count) plus one payload byte and a status result.
	typedef struct packed {
		logic [2:0] nres;   // number of results 0..5
		logic magic;        // first four results are the PACK magic
		logic [7:0] data;   // trailing byte result
		okind_t kind;       // kind of trailing byte result
		logic has_data;     // a trailing byte result exists
		logic fin;          // a status result follows
		logic [3:0] status;
		logic ack;
		logic [31:0] count;
	} job_t;

	function automatic logic [7:0] magic_byte(input logic [1:0] i);
		unique case (i)
			2'd0: magic_byte = 8'h50;
			2'd1: magic_byte = 8'h41;
			2'd2: magic_byte = 8'h43;
			default: magic_byte = 8'h4B;
		endcase
	endfunction

	function automatic logic [7:0] pfx_char(input logic [2:0] k, input logic [3:0] p);
		logic [8*10-1:0] s;
		begin
			unique case (k)
				3'd0: s = {"NAK\n", 48'h0};
				3'd1: s = {"ACK ", 48'h0};
				3'd2: s = {"shallow ", 16'h0};
				3'd3: s = "unshallow ";
				3'd4: s = {"ERR ", 48'h0};
				default: s = {"PACK", 48'h0};
			endcase
			pfx_char = (p < 4'd10) ? s[8*(9-p) +: 8] : 8'h00;
		end
	endfunction

	function automatic logic [3:0] pfx_len(input logic [2:0] k);
		unique case (k)
			3'd2: pfx_len = 4'd8;
			3'd3: pfx_len = 4'd10;
			default: pfx_len = 4'd4;
		endcase
	endfunction
endpackage

// ===== src/plsd_if.sv =====
// Valid/ready stream interfaces for input items and results.
interface plsd_in_if;
	logic valid;
	logic ready;
	logic [7:0] in_byte;
	logic has_byte;
	logic is_last;
	modport source (output valid, in_byte, has_byte, is_last, input ready);
	modport sink (input valid, in_byte, has_byte, is_last, output ready);
endinterface

interface plsd_out_if;
	logic valid;
	logic ready;
	logic [7:0] out_byte;
	logic [1:0] out_kind;
	logic [3:0] status;
	logic acknowledged;
	logic [31:0] object_count;
	logic out_last;
	modport source (output valid, out_byte, out_kind, status, acknowledged, object_count,
		out_last, input ready);
	modport sink (input valid, out_byte, out_kind, status, acknowledged, object_count,
		out_last, output ready);
endinterface

// ===== src/plsd_front.sv =====
// Front end: deframes and classifies each byte, producing one job for each item with results.
module plsd_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [7:0] in_byte,
	input  logic has_byte,
	input  logic is_last,
	output logic job_valid,
	input  logic job_ready,
	output plsd_pkg::job_t job
);
	plsd_pkg::phase_t phase_q, phase_d;
	logic [1:0] hdc_q, hdc_d;
	logic [15:0] len_q, len_d;
	logic mag_q, mag_d, hex_q, hex_d;
	logic [15:0] left_q, left_d;
	logic [3:0] pos_q, pos_d;
	logic [5:0] cand_q, cand_d;
	plsd_pkg::pkind_t pk_q, pk_d;
	logic ack_q, ack_d;
	logic [5:0] pbc_q, pbc_d;
	logic [7:0] hdr_q [plsd_pkg::HDR_BYTES];
	logic [3:0] err_q, err_d;

	logic acc;
	logic [7:0] b;
	logic ishex;
	logic [3:0] hv;
	logic [15:0] lnew;
	logic emit_mag, emit_b;
	plsd_pkg::okind_t bkind;
	logic [5:0] cnew;
	logic [3:0] pnext;
	logic [5:0] pbc_mid;
	logic [31:0] ver, cnt;
	logic [3:0] st;
	logic [31:0] cnt_o;
	logic mag_ok;

	assign in_ready = job_ready;
	assign acc = in_valid && in_ready;
	assign b = in_byte;

	always_comb begin
		ishex = 1'b1;
		hv = 4'd0;
		if (b >= 8'h30 && b <= 8'h39) hv = b[3:0];
		else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
			hv = b[3:0] + 4'd9;
		else ishex = 1'b0;
	end
	assign lnew = {len_q[11:0], 4'd0} | {12'd0, hv};

	always_comb begin
		phase_d = phase_q; hdc_d = hdc_q; len_d = len_q; mag_d = mag_q; hex_d = hex_q;
		left_d = left_q; pos_d = pos_q; cand_d = cand_q; pk_d = pk_q; ack_d = ack_q;
		err_d = err_q; emit_mag = 1'b0; emit_b = 1'b0; bkind = plsd_pkg::KIND_PACK;
		cnew = cand_q; pnext = pos_q;
		if (has_byte) begin
			unique case (phase_q)
				plsd_pkg::PH_START, plsd_pkg::PH_HEADER: begin
					phase_d = plsd_pkg::PH_HEADER;
					if (hdc_q != 2'd3) begin
						hdc_d = hdc_q + 2'd1;
						len_d = lnew;
						mag_d = mag_q && (b == plsd_pkg::magic_byte(hdc_q));
						hex_d = hex_q && ishex;
					end else begin
						hdc_d = 2'd0; len_d = 16'd0; mag_d = 1'b1; hex_d = 1'b1;
						if (mag_q && b == plsd_pkg::magic_byte(2'd3)) begin
							phase_d = plsd_pkg::PH_RAW; emit_mag = 1'b1;
						end else if (!(hex_q && ishex)) begin
							phase_d = plsd_pkg::PH_ERROR; err_d = plsd_pkg::ST_BAD_LEN;
						end else if (lnew == 16'd3) begin
							phase_d = plsd_pkg::PH_ERROR; err_d = plsd_pkg::ST_TRUNC;
						end else if (lnew > 16'd4) begin
							phase_d = plsd_pkg::PH_BODY; left_d = lnew - 16'd4;
							pos_d = 4'd0; cand_d = 6'h3F; pk_d = plsd_pkg::PK_UND;
						end
					end
				end
				plsd_pkg::PH_BODY: begin
					unique case (pk_q)
						plsd_pkg::PK_UND: begin
							if (pos_q == 4'd0 && b >= 8'd1 && b <= 8'd3) begin
								if (b == 8'd1) pk_d = plsd_pkg::PK_DATA;
								else if (b == 8'd2) pk_d = plsd_pkg::PK_PROG;
								else begin
									pk_d = plsd_pkg::PK_REJECT; err_d = plsd_pkg::ST_FATAL;
								end
							end else begin
								for (int i = 0; i < 6; i++)
									if (!(pos_q < plsd_pkg::pfx_len(3'(i)) &&
										plsd_pkg::pfx_char(3'(i), pos_q) == b))
										cnew[i] = 1'b0;
								pnext = (pos_q < 4'd15) ? pos_q + 4'd1 : pos_q;
								cand_d = cnew; pos_d = pnext;
								if (cnew == 6'd0) begin
									pk_d = plsd_pkg::PK_REJECT; err_d = plsd_pkg::ST_UNEXP;
								end else if (cnew[1] && pnext == 4'd4) pk_d = plsd_pkg::PK_ACK;
								else if (cnew[2] && pnext == 4'd8) pk_d = plsd_pkg::PK_SKIP;
								else if (cnew[3] && pnext == 4'd10) pk_d = plsd_pkg::PK_SKIP;
								else if (cnew[4] && pnext == 4'd4) begin
									pk_d = plsd_pkg::PK_REJECT; err_d = plsd_pkg::ST_ERR;
								end else if (cnew[5] && pnext == 4'd4) begin
									pk_d = plsd_pkg::PK_INPACK; emit_mag = 1'b1;
								end
							end
						end
						plsd_pkg::PK_DATA, plsd_pkg::PK_INPACK: emit_b = 1'b1;
						plsd_pkg::PK_PROG: begin
							emit_b = 1'b1; bkind = plsd_pkg::KIND_PROG;
						end
						default: ;
					endcase
					left_d = (left_q != 16'd0) ? left_q - 16'd1 : left_q;
					if (left_d == 16'd0) begin
						if (pk_d == plsd_pkg::PK_UND) begin
							if (cand_d[0] && pos_d >= 4'd3) pk_d = plsd_pkg::PK_SKIP;
							else begin
								pk_d = plsd_pkg::PK_REJECT; err_d = plsd_pkg::ST_UNEXP;
							end
						end
						if (pk_d == plsd_pkg::PK_ACK) ack_d = 1'b1;
						phase_d = (pk_d == plsd_pkg::PK_REJECT) ? plsd_pkg::PH_ERROR :
							plsd_pkg::PH_HEADER;
					end
				end
				plsd_pkg::PH_RAW: emit_b = 1'b1;
				default: ;
			endcase
		end
	end

	// Pack byte count after the magic and byte of this item.
	assign pbc_mid = emit_mag ? ((pbc_q > 6'd28) ? plsd_pkg::PACK_MIN : pbc_q + 6'd4) : pbc_q;
	always_comb begin
		pbc_d = pbc_mid;
		if (emit_b && bkind == plsd_pkg::KIND_PACK && pbc_mid < plsd_pkg::PACK_MIN)
			pbc_d = pbc_mid + 6'd1;
	end

	// The final check sees the pack header including writes of this item.
	logic [7:0] hn [plsd_pkg::HDR_BYTES];
	always_comb begin
		for (int i = 0; i < plsd_pkg::HDR_BYTES; i++) begin
			hn[i] = hdr_q[i];
			if (emit_mag && 6'(i) >= pbc_q && 6'(i) < pbc_q + 6'd4)
				hn[i] = plsd_pkg::magic_byte(2'(6'(i) - pbc_q));
			if (emit_b && bkind == plsd_pkg::KIND_PACK && 6'(i) == pbc_mid) hn[i] = b;
		end
	end

	assign mag_ok = hn[0] == 8'h50 && hn[1] == 8'h41 && hn[2] == 8'h43 && hn[3] == 8'h4B;
	assign ver = {hn[4], hn[5], hn[6], hn[7]};
	assign cnt = {hn[8], hn[9], hn[10], hn[11]};
	always_comb begin
		cnt_o = 32'd0;
		if (phase_d == plsd_pkg::PH_ERROR) st = err_d;
		else if (phase_d == plsd_pkg::PH_START) st = plsd_pkg::ST_EMPTY;
		else if (phase_d == plsd_pkg::PH_HEADER && hdc_d != 2'd0) st = plsd_pkg::ST_HDR_CUT;
		else if (phase_d == plsd_pkg::PH_BODY) st = plsd_pkg::ST_TRUNC;
		else if (pbc_d == 6'd0 && ack_d) st = plsd_pkg::ST_OK;
		else if (pbc_d < plsd_pkg::PACK_MIN || !mag_ok) st = plsd_pkg::ST_INCOMPLETE;
		else if (ver != 32'd2 && ver != 32'd3) st = plsd_pkg::ST_BAD_VER;
		else begin
			st = plsd_pkg::ST_OK; cnt_o = cnt;
		end
	end

	always_comb begin
		job.magic = emit_mag;
		job.data = b;
		job.kind = bkind;
		job.has_data = emit_b;
		job.fin = is_last;
		job.status = st;
		job.ack = ack_d;
		job.count = cnt_o;
		job.nres = (emit_mag ? 3'd4 : 3'd0) + {2'd0, emit_b} + {2'd0, is_last};
	end
	assign job_valid = in_valid && (job.nres != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= plsd_pkg::PH_START; hdc_q <= '0; len_q <= '0; mag_q <= 1'b1;
			hex_q <= 1'b1; left_q <= '0; pos_q <= '0; cand_q <= 6'h3F;
			pk_q <= plsd_pkg::PK_UND; ack_q <= 1'b0; pbc_q <= '0; err_q <= '0;
		end else if (acc) begin
			if (is_last) begin
				phase_q <= plsd_pkg::PH_START; hdc_q <= '0; len_q <= '0; mag_q <= 1'b1;
				hex_q <= 1'b1; left_q <= '0; pos_q <= '0; cand_q <= 6'h3F;
				pk_q <= plsd_pkg::PK_UND; ack_q <= 1'b0; pbc_q <= '0; err_q <= '0;
			end else begin
				phase_q <= phase_d; hdc_q <= hdc_d; len_q <= len_d; mag_q <= mag_d;
				hex_q <= hex_d; left_q <= left_d; pos_q <= pos_d; cand_q <= cand_d;
				pk_q <= pk_d; ack_q <= ack_d; pbc_q <= pbc_d; err_q <= err_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) for (int i = 0; i < plsd_pkg::HDR_BYTES; i++) hdr_q[i] <= hn[i];
	end
endmodule

// ===== src/plsd_queue.sv =====
// Short job queue between the front and back ends.
module plsd_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  plsd_pkg::job_t wr_job,
	output logic rd_valid,
	input  logic rd_ready,
	output plsd_pkg::job_t rd_job
);
	plsd_pkg::job_t mem_q [plsd_pkg::QDEPTH];
	logic [plsd_pkg::QAW-1:0] wp_q, rp_q;
	logic [plsd_pkg::QAW:0] cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != 3'(plsd_pkg::QDEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_job = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + {2'd0, wr} - {2'd0, rd};
		end
	end
	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_job;
	end
endmodule

// ===== src/plsd_back.sv =====
// Back end: expands each job into its results, one result per cycle while res_ready is high.
module plsd_back (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	output logic job_ready,
	input  plsd_pkg::job_t job,
	output logic res_valid,
	input  logic res_ready,
	output plsd_pkg::res_t res
);
	logic [2:0] idx_q;
	logic [2:0] nres;
	logic take, lastres;

	assign nres = job.nres;
	assign take = job_valid && res_ready;
	assign lastres = (idx_q + 3'd1 == nres);
	assign job_ready = res_ready && lastres;
	assign res_valid = job_valid;

	always_comb begin
		res = '0;
		if (job.magic && idx_q < 3'd4) begin
			res.data = plsd_pkg::magic_byte(idx_q[1:0]);
			res.kind = plsd_pkg::KIND_PACK;
		end else if (job.has_data && (idx_q == (job.magic ? 3'd4 : 3'd0))) begin
			res.data = job.data;
			res.kind = job.kind;
		end else begin
			res.kind = plsd_pkg::KIND_STATUS;
			res.status = job.status;
			res.ack = job.ack;
			res.count = job.count;
			res.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) idx_q <= '0;
		else if (take) idx_q <= lastres ? 3'd0 : idx_q + 3'd1;
	end
endmodule

// ===== src/pkt_line_sideband_deframer_unit.sv =====
// Top level of the pkt-line side-band deframer.
// The block takes a response one byte per transfer on in_ch and gives pack bytes,
// progress bytes and one final status on out_ch. An input transfer with has_byte low
// and is_last low does nothing and yields no result.
// The front end decides each byte in the cycle it is accepted, so one item is taken
// every cycle while the four-entry job queue has room. An item that yields results
// becomes one job; header and skipped bytes yield none unless they complete "PACK" or
// end the response. The back end plays a job out as one to five results, one per
// cycle while out_ch is ready, straight from the queue head, where each job is
// registered first. A byte that completes "PACK" yields the four magic bytes, and a
// fifth result when it also ends the response, so the input runs at one item per
// cycle while items yield at most one result each; the output sets the pace otherwise.
// Reset clears all control state; the block starts awaiting the first byte. After
// accepting the is_last item the front end returns to that state. When the receiver
// stalls, results wait at the queue head and input keeps flowing until the queue
// fills, then in_ch ready drops.
`include "pkt_line_sideband_deframer_unit_defines.svh"
module pkt_line_sideband_deframer_unit (
	input  logic clk,
	input  logic arst_n,
	plsd_in_if.sink in_ch,
	plsd_out_if.source out_ch
);
	logic jv, jr, qv, qr;
	plsd_pkg::job_t job_f, job_b;
	plsd_pkg::res_t res;
	logic fr_ready;

	// The front end updates state on every accepted transfer; empty ones leave it unchanged.
	plsd_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(fr_ready),
		.in_byte(in_ch.in_byte), .has_byte(in_ch.has_byte), .is_last(in_ch.is_last),
		.job_valid(jv), .job_ready(jr), .job(job_f)
	);
	assign in_ch.ready = fr_ready;

	plsd_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_valid(jv), .wr_ready(jr), .wr_job(job_f),
		.rd_valid(qv), .rd_ready(qr), .rd_job(job_b)
	);

	plsd_back u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(qv), .job_ready(qr), .job(job_b),
		.res_valid(out_ch.valid), .res_ready(out_ch.ready), .res(res)
	);

	assign out_ch.out_byte = res.data;
	assign out_ch.out_kind = res.kind;
	assign out_ch.status = res.status;
	assign out_ch.acknowledged = res.ack;
	assign out_ch.object_count = res.count;
	assign out_ch.out_last = res.last;

	`PLSD_ASSERT_IMP(a_last_is_status, clk, arst_n, out_ch.valid && out_ch.out_last,
		out_ch.out_kind == plsd_pkg::KIND_STATUS, "final result without status kind")
	`PLSD_ASSERT_IMP(a_byte_no_status, clk, arst_n,
		out_ch.valid && !out_ch.out_last, out_ch.status == plsd_pkg::ST_OK,
		"byte result carries a status")
	`PLSD_ASSERT_NEXT(a_stall_holds, clk, arst_n, out_ch.valid && !out_ch.ready,
		out_ch.valid && $stable(out_ch.out_byte), "stalled result changed")
endmodule
